// File: rtl/token_bucket_packet_pacer_core_defines.svh
// assertion helpers for the token bucket pacer
`ifndef TOKEN_BUCKET_PACKET_PACER_CORE_DEFINES_SVH
`define TOKEN_BUCKET_PACKET_PACER_CORE_DEFINES_SVH

// same-cycle implication
`define TBPP_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TBPP_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tbpp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tbpp_pkg;

  localparam int unsigned QueueDepthDef = 16;

  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int LEN_W      = 16;
  localparam int EL_W       = 32;
  localparam int ELC_W      = 31;
  localparam int TOK_W      = 34;
  localparam int BAL_W      = 33;
  localparam int QUOT_W     = 44;
  localparam int KIND_W     = 2;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 56;

  // 1000000 = 64 * 15625, quotient by 15625 through a reciprocal scaled by 2^71
  localparam int MUL_W    = 32;
  localparam int PRE_SH   = 6;
  localparam int SCALED_W = 57;
  localparam int RECIP_W  = 58;
  localparam int ACC_W    = 60;
  localparam int POST_SH  = 7;

  localparam logic [ELC_W-1:0]   ELAPSED_MAX = 31'd2000000000;
  localparam logic [RECIP_W-1:0] RECIP_15625 = 58'd151115727451828647;
  localparam logic [CFG_W-1:0]   MIN_BUCKET  = 32'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BYTE_RATE       = 2'd0,
    CFG_BUCKET_SIZE     = 2'd1,
    CFG_MAX_QUEUE_BYTES = 2'd2
  } tbpp_cfg_idx_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_DROP   = 2'd1,
    KIND_SENT   = 2'd2,
    KIND_IDLE   = 2'd3
  } tbpp_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REFILL,
    ST_CAP,
    ST_DRAIN,
    ST_SEND
  } tbpp_state_e;

  typedef enum logic [2:0] {
    RF_IDLE,
    RF_MUL,
    RF_LL,
    RF_LH,
    RF_HL,
    RF_HH
  } tbpp_refill_e;

  typedef struct packed {
    logic busy;
    logic done;
  } tbpp_refill_stat_t;

endpackage

`default_nettype wire

// File: rtl/tbpp_len_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module tbpp_len_mem #(
  parameter int unsigned DEPTH = tbpp_pkg::QueueDepthDef
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [tbpp_pkg::LEN_W-1:0]       wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [tbpp_pkg::LEN_W-1:0]       rdata_o
);
  import tbpp_pkg::*;

  logic [LEN_W-1:0] mem_q [DEPTH];
  logic [LEN_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/tbpp_refill.sv
`timescale 1ns / 1ps
`default_nettype none

module tbpp_refill (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [tbpp_pkg::ELC_W-1:0]        elapsed_i,
  input  logic [tbpp_pkg::CFG_W-1:0]        rate_i,
  output tbpp_pkg::tbpp_refill_stat_t       stat_o,
  output logic [tbpp_pkg::QUOT_W-1:0]       quot_o
);
  import tbpp_pkg::*;

  tbpp_refill_e        st_q, st_d;
  logic [ELC_W-1:0]    el_q, el_d;
  logic [SCALED_W-1:0] y_q, y_d;
  logic [ACC_W-1:0]    acc_q, acc_d;
  logic [QUOT_W-1:0]   quot_q, quot_d;

  logic [MUL_W-1:0]    mul_a;
  logic [MUL_W-1:0]    mul_b;
  logic [2*MUL_W-1:0]  mul_p;
  logic [2*MUL_W-1:0]  top_sum;

  // one shared 32x32 multiplier, operands picked per state
  assign mul_p   = (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);
  assign top_sum = (2*MUL_W)'(acc_q[ACC_W-1:MUL_W]) + mul_p;

  always_comb begin
    st_d   = st_q;
    el_d   = el_q;
    y_d    = y_q;
    acc_d  = acc_q;
    quot_d = quot_q;
    mul_a  = '0;
    mul_b  = '0;
    unique case (st_q)
      RF_IDLE: begin
        if (start_i) begin
          el_d = elapsed_i;
          st_d = RF_MUL;
        end
      end
      RF_MUL: begin
        mul_a = MUL_W'(el_q);
        mul_b = rate_i;
        y_d   = mul_p[SCALED_W+PRE_SH-1:PRE_SH];
        st_d  = RF_LL;
      end
      RF_LL: begin
        mul_a = y_q[MUL_W-1:0];
        mul_b = RECIP_15625[MUL_W-1:0];
        acc_d = ACC_W'(mul_p[2*MUL_W-1:MUL_W]);
        st_d  = RF_LH;
      end
      RF_LH: begin
        mul_a = y_q[MUL_W-1:0];
        mul_b = MUL_W'(RECIP_15625[RECIP_W-1:MUL_W]);
        acc_d = acc_q + ACC_W'(mul_p);
        st_d  = RF_HL;
      end
      RF_HL: begin
        mul_a = MUL_W'(y_q[SCALED_W-1:MUL_W]);
        mul_b = RECIP_15625[MUL_W-1:0];
        acc_d = acc_q + ACC_W'(mul_p);
        st_d  = RF_HH;
      end
      RF_HH: begin
        mul_a  = MUL_W'(y_q[SCALED_W-1:MUL_W]);
        mul_b  = MUL_W'(RECIP_15625[RECIP_W-1:MUL_W]);
        quot_d = top_sum[QUOT_W+POST_SH-1:POST_SH];
        st_d   = RF_IDLE;
      end
      default: st_d = RF_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= RF_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    el_q   <= el_d;
    y_q    <= y_d;
    acc_q  <= acc_d;
    quot_q <= quot_d;
  end

  assign stat_o.busy = st_q != RF_IDLE;
  assign stat_o.done = st_q == RF_HH;
  assign quot_o      = quot_q;

endmodule

`default_nettype wire

// File: rtl/token_bucket_packet_pacer_core.sv
// an append status is registered and valid in the cycle after its transfer
// a nonzero tick runs a 32x32 multiply and a four-step reciprocal multiply
// by 1/1000000, then the bucket cap step, before draining starts
// a new item is taken only once the last one is done; a sent packet needs a queue memory
// read, then the result register, and output stalls stretch all of this
// reset: control and queue counters clear at once, tokens and bucket size load 4096, no clearing pass
`timescale 1ns / 1ps
`default_nettype none
`include "token_bucket_packet_pacer_core_defines.svh"

module token_bucket_packet_pacer_core #(
  parameter int unsigned QUEUE_DEPTH = tbpp_pkg::QueueDepthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tbpp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tbpp_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // pkt_length, tick_span
  input  logic [tbpp_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // func
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // sent_length, token_balance, zero pad
  output logic [tbpp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // kind
  output logic [tbpp_pkg::KIND_W-1:0]         m_axis_tuser,
  output logic                                m_axis_tlast
);
  import tbpp_pkg::*;

  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int BYTES_W = $clog2(QUEUE_DEPTH * 65535 + 1);
  localparam int SUM_W   = QUOT_W + 2;
  localparam int PAD_W   = OUT_DATA_W - LEN_W - BAL_W;

  tbpp_state_e       state_q, state_d;
  logic [CFG_W-1:0]  byte_rate_q, byte_rate_d;
  logic [CFG_W-1:0]  bucket_q, bucket_d;
  logic [CFG_W-1:0]  max_bytes_q, max_bytes_d;
  logic [TOK_W-1:0]  tokens_q, tokens_d;
  logic [PTR_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [BYTES_W-1:0] bytes_q, bytes_d;
  logic              sent_q, sent_d;

  logic              m_valid_q, m_valid_d;
  tbpp_kind_e        m_kind_q, m_kind_d;
  logic [LEN_W-1:0]  m_len_q, m_len_d;
  logic [BAL_W-1:0]  m_bal_q, m_bal_d;
  logic              m_last_q, m_last_d;

  logic              out_free;
  logic              in_fire;
  logic [LEN_W-1:0]  in_len;
  logic [EL_W-1:0]   in_el;
  logic [ELC_W-1:0]  el_clamp;
  logic [PTR_W:0]    tail_sum;
  logic [PTR_W:0]    tail_wrap;
  logic [PTR_W-1:0]  tail;
  logic              drop;
  logic              tokens_pos;
  logic [TOK_W-1:0]  tok_after;
  logic              tok_after_pos;
  logic [SUM_W-1:0]  cap_sum;
  logic              cap_hit;
  logic [CFG_W-1:0]  bucket_new;

  logic              mem_we;
  logic              mem_re;
  logic [LEN_W-1:0]  mem_rdata;
  logic              refill_start;
  tbpp_refill_stat_t refill_stat;
  logic [QUOT_W-1:0] refill_quot;

  tbpp_len_mem #(
    .DEPTH (QUEUE_DEPTH)
  ) u_len_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (tail),
    .wdata_i (in_len),
    .re_i    (mem_re),
    .raddr_i (head_q),
    .rdata_o (mem_rdata)
  );

  tbpp_refill u_refill (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (refill_start),
    .elapsed_i (el_clamp),
    .rate_i    (byte_rate_q),
    .stat_o    (refill_stat),
    .quot_o    (refill_quot)
  );

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_len        = s_axis_tdata[LEN_W-1:0];
  assign in_el         = s_axis_tdata[LEN_W+EL_W-1:LEN_W];
  assign el_clamp      = (in_el > {1'b0, ELAPSED_MAX}) ? ELAPSED_MAX : in_el[ELC_W-1:0];

  assign tail_sum  = (PTR_W+1)'(head_q) + (PTR_W+1)'(count_q);
  assign tail_wrap = tail_sum - (PTR_W+1)'(QUEUE_DEPTH);
  assign tail      = (tail_sum >= (PTR_W+1)'(QUEUE_DEPTH)) ? tail_wrap[PTR_W-1:0]
                                                           : tail_sum[PTR_W-1:0];

  assign drop = (in_len == '0) || (count_q == CNT_W'(QUEUE_DEPTH)) ||
                ((max_bytes_q != '0) &&
                 ((CFG_W+1)'(bytes_q) + (CFG_W+1)'(in_len) > {1'b0, max_bytes_q}));

  assign tokens_pos    = !tokens_q[TOK_W-1] && (tokens_q != '0);
  assign tok_after     = tokens_q - TOK_W'(mem_rdata);
  assign tok_after_pos = !tok_after[TOK_W-1] && (tok_after != '0);

  assign cap_sum = {{(SUM_W-TOK_W){tokens_q[TOK_W-1]}}, tokens_q} + SUM_W'(refill_quot);
  assign cap_hit = !cap_sum[SUM_W-1] && (cap_sum > SUM_W'(bucket_q));

  assign bucket_new = (cfg_data_i < MIN_BUCKET) ? MIN_BUCKET : cfg_data_i;

  always_comb begin
    state_d      = state_q;
    byte_rate_d  = byte_rate_q;
    bucket_d     = bucket_q;
    max_bytes_d  = max_bytes_q;
    tokens_d     = tokens_q;
    head_d       = head_q;
    count_d      = count_q;
    bytes_d      = bytes_q;
    sent_d       = sent_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    m_kind_d     = m_kind_q;
    m_len_d      = m_len_q;
    m_bal_d      = m_bal_q;
    m_last_d     = m_last_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    refill_start = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (!s_axis_tuser) begin
            mem_we    = !drop;
            if (!drop) begin
              count_d = count_q + 1'b1;
              bytes_d = bytes_q + BYTES_W'(in_len);
            end
            m_valid_d = 1'b1;
            m_kind_d  = drop ? KIND_DROP : KIND_ACCEPT;
            m_len_d   = '0;
            m_bal_d   = tokens_q[BAL_W-1:0];
            m_last_d  = !(tokens_pos && ((count_q != '0) || !drop));
            sent_d    = 1'b1;
            state_d   = ST_DRAIN;
          end else begin
            sent_d = 1'b0;
            if (el_clamp == '0) begin
              state_d = ST_DRAIN;
            end else begin
              refill_start = 1'b1;
              state_d      = ST_REFILL;
            end
          end
        end
      end
      ST_REFILL: begin
        if (refill_stat.done) begin
          state_d = ST_CAP;
        end
      end
      ST_CAP: begin
        tokens_d = cap_hit ? TOK_W'(bucket_q) : cap_sum[TOK_W-1:0];
        state_d  = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (tokens_pos && (count_q != '0)) begin
          mem_re  = 1'b1;
          state_d = ST_SEND;
        end else if (sent_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          m_valid_d = 1'b1;
          m_kind_d  = KIND_IDLE;
          m_len_d   = '0;
          m_bal_d   = tokens_q[BAL_W-1:0];
          m_last_d  = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      ST_SEND: begin
        if (out_free) begin
          tokens_d  = tok_after;
          bytes_d   = bytes_q - BYTES_W'(mem_rdata);
          count_d   = count_q - 1'b1;
          head_d    = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
          m_valid_d = 1'b1;
          m_kind_d  = KIND_SENT;
          m_len_d   = mem_rdata;
          m_bal_d   = tok_after[BAL_W-1:0];
          m_last_d  = !(tok_after_pos && (count_q != CNT_W'(1)));
          sent_d    = 1'b1;
          state_d   = ST_DRAIN;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BYTE_RATE:       byte_rate_d = cfg_data_i;
        CFG_BUCKET_SIZE: begin
          bucket_d = bucket_new;
          tokens_d = TOK_W'(bucket_new);
        end
        CFG_MAX_QUEUE_BYTES: max_bytes_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      byte_rate_q <= '0;
      bucket_q    <= MIN_BUCKET;
      max_bytes_q <= '0;
      tokens_q    <= TOK_W'(MIN_BUCKET);
      head_q      <= '0;
      count_q     <= '0;
      bytes_q     <= '0;
      sent_q      <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      byte_rate_q <= byte_rate_d;
      bucket_q    <= bucket_d;
      max_bytes_q <= max_bytes_d;
      tokens_q    <= tokens_d;
      head_q      <= head_d;
      count_q     <= count_d;
      bytes_q     <= bytes_d;
      sent_q      <= sent_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_kind_q <= m_kind_d;
    m_len_q  <= m_len_d;
    m_bal_q  <= m_bal_d;
    m_last_q <= m_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, m_bal_q, m_len_q};
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tlast  = m_last_q;

  `TBPP_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH), "queue count overflow")
  `TBPP_ASSERT_IMP(a_empty_bytes, count_q == '0, bytes_q == '0, "bytes left in empty queue")
  `TBPP_ASSERT_NXT(a_send_pop, (state_q == ST_SEND) && out_free,
                   count_q == $past(count_q) - 1'b1, "send without pop")
  `TBPP_ASSERT_IMP(a_refill_idle, state_q == ST_IDLE, !refill_stat.busy,
                   "refill unit busy while idle")

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import tbpp_pkg::*;

  localparam int DEPTH = QueueDepthDef;
  localparam longint unsigned TICK_CAP = 64'd2000000000;
  localparam longint unsigned US_PER_SEC = 64'd1000000;
  localparam longint BUCKET_FLOOR = 64'd4096;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_TICK = 1'b1;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 100;
  localparam int CHUNK_ITEMS = 38;
  localparam int CHUNKS = 4;

  typedef struct {
    tbpp_kind_e kind;
    logic [LEN_W-1:0] sent_len;
    logic [BAL_W-1:0] balance;
    logic last;
  } shaped_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // pkt_length, tick_span
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  // func
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // sent_length, token_balance, zero pad
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // kind
  logic [KIND_W-1:0] m_axis_tuser;
  logic m_axis_tlast;

  int send_idle_pct = 15;
  int recv_idle_pct = 86;
  int mismatches = 0;
  int cycle_count = 0;

  // shaper mirror
  logic [31:0] rate_reg = '0;
  longint bucket_reg = BUCKET_FLOOR;
  logic [31:0] byte_cap_reg = '0;
  longint tokens = BUCKET_FLOOR;
  logic [LEN_W-1:0] fifo_len[DEPTH];
  int fifo_head = 0;
  int fifo_count = 0;
  longint unsigned fifo_bytes = 0;

  shaped_result_t shaped_results[$];

  token_bucket_packet_pacer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic void emit(tbpp_kind_e kind, logic [LEN_W-1:0] len);
    shaped_result_t r;
    r.kind = kind;
    r.sent_len = len;
    r.balance = tokens[BAL_W-1:0];
    r.last = 1'b0;
    shaped_results.push_back(r);
  endfunction

  function automatic void predict_shaping(logic func, logic [LEN_W-1:0] len,
                                          logic [EL_W-1:0] el);
    longint unsigned span;
    logic drop;
    logic [LEN_W-1:0] head_len;
    int n;
    n = 0;
    if (func == FUNC_APPEND) begin
      drop = (len == 0) || (fifo_count >= DEPTH) ||
             (byte_cap_reg != 0 && fifo_bytes + len > byte_cap_reg);
      if (!drop) begin
        fifo_len[(fifo_head + fifo_count) % DEPTH] = len;
        fifo_count++;
        fifo_bytes += len;
        emit(KIND_ACCEPT, '0);
      end else begin
        emit(KIND_DROP, '0);
      end
      n++;
    end else begin
      span = (el > TICK_CAP) ? TICK_CAP : longint'(el);
      if (span != 0) begin
        tokens = tokens + longint'((span * rate_reg) / US_PER_SEC);
        if (tokens > bucket_reg) tokens = bucket_reg;
      end
    end
    while (tokens > 0 && fifo_count > 0) begin
      head_len = fifo_len[fifo_head];
      tokens = tokens - longint'(head_len);
      fifo_bytes -= head_len;
      fifo_head = (fifo_head + 1) % DEPTH;
      fifo_count--;
      emit(KIND_SENT, head_len);
      n++;
    end
    if (n == 0) emit(KIND_IDLE, '0);
    shaped_results[shaped_results.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk_i) begin : check_results
    shaped_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (shaped_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result kind %0d len %0d", $time, m_axis_tuser,
                 m_axis_tdata[LEN_W-1:0]);
      end else begin
        want = shaped_results.pop_front();
        if (m_axis_tuser != want.kind) begin
          mismatches++;
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, m_axis_tuser);
        end
        if (m_axis_tdata[LEN_W-1:0] != want.sent_len) begin
          mismatches++;
          $display("%0t: sent_length expected %0d actual %0d", $time, want.sent_len,
                   m_axis_tdata[LEN_W-1:0]);
        end
        if (m_axis_tdata[LEN_W +: BAL_W] != want.balance) begin
          mismatches++;
          $display("%0t: token_balance expected %0d actual %0d", $time,
                   $signed(want.balance), $signed(m_axis_tdata[LEN_W +: BAL_W]));
        end
        if (m_axis_tlast != want.last) begin
          mismatches++;
          $display("%0t: last expected %0d actual %0d", $time, want.last, m_axis_tlast);
        end
      end
    end
  end

  task automatic push_item(input logic func, input logic [LEN_W-1:0] len,
                           input logic [EL_W-1:0] el);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= func;
    s_axis_tdata <= {el, len};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_shaping(func, len, el);
    @(negedge clk_i);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (shaped_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (idx)
      CFG_BYTE_RATE: rate_reg = value;
      CFG_BUCKET_SIZE: begin
        bucket_reg = (value < BUCKET_FLOOR) ? BUCKET_FLOOR : longint'(value);
        tokens = bucket_reg;
      end
      CFG_MAX_QUEUE_BYTES: byte_cap_reg = value;
      default: ;
    endcase
  endtask

  task automatic test_idle_and_zero_length();
    push_item(FUNC_TICK, 16'd0, 32'd0);
    push_item(FUNC_APPEND, 16'd0, 32'hFFFF_FFFF);
  endtask

  task automatic test_full_queue();
    // deficit first so the queue backs up
    push_item(FUNC_APPEND, 16'hFFFF, '0);
    for (int i = 0; i < DEPTH; i++) begin
      push_item(FUNC_APPEND, (i == 0) ? 16'd1 : 16'($urandom_range(65535, 1)), $urandom);
    end
    push_item(FUNC_APPEND, 16'd100, '0);
    settle();
    write_reg(CFG_BUCKET_SIZE, 32'hFFFF_FFFF);
    // drop status then the whole queue drains
    push_item(FUNC_APPEND, 16'd0, '0);
  endtask

  task automatic test_byte_limit();
    settle();
    write_reg(CFG_MAX_QUEUE_BYTES, 32'd100);
    write_reg(CFG_BUCKET_SIZE, 32'd0);
    push_item(FUNC_APPEND, 16'hFFFF, '0);
    push_item(FUNC_APPEND, 16'd60, '0);
    push_item(FUNC_APPEND, 16'd41, '0);
    push_item(FUNC_APPEND, 16'd40, '0);
  endtask

  task automatic test_long_ticks();
    settle();
    write_reg(CFG_BYTE_RATE, 32'd1);
    push_item(FUNC_TICK, 16'hFFFF, 32'hFFFF_FFFF);
    settle();
    write_reg(CFG_BYTE_RATE, 32'hFFFF_FFFF);
    push_item(FUNC_TICK, '0, 32'd2000000001);
    settle();
    write_reg(CFG_SPARE, 32'hFFFF_FFFF);
    write_reg(CFG_MAX_QUEUE_BYTES, 32'hFFFF_FFFF);
    write_reg(CFG_BUCKET_SIZE, 32'd4095);
  endtask

  task automatic reconfigure_random();
    logic [CFG_W-1:0] rate;
    logic [CFG_W-1:0] bucket;
    logic [CFG_W-1:0] cap;
    case ($urandom_range(5))
      0: rate = 32'd0;
      1: rate = 32'd1;
      2: rate = 32'd1000000;
      3: rate = $urandom_range(5000000, 10000);
      4: rate = 32'hFFFF_FFFF;
      default: rate = $urandom;
    endcase
    case ($urandom_range(3))
      0: bucket = $urandom_range(4095, 0);
      1: bucket = $urandom_range(200000, 4096);
      2: bucket = 32'hFFFF_FFFF;
      default: bucket = $urandom;
    endcase
    case ($urandom_range(3))
      0, 1: cap = 32'd0;
      2: cap = $urandom_range(300000, 1);
      default: cap = $urandom;
    endcase
    write_reg(CFG_BYTE_RATE, rate);
    write_reg(CFG_BUCKET_SIZE, bucket);
    write_reg(CFG_MAX_QUEUE_BYTES, cap);
    if ($urandom_range(3) == 0) write_reg(CFG_SPARE, $urandom);
  endtask

  task automatic push_random_item();
    logic [LEN_W-1:0] len;
    logic [EL_W-1:0] el;
    if ($urandom_range(9) < 6) begin
      case ($urandom_range(19))
        0: len = 16'd0;
        1, 2: len = $urandom;
        3: len = 16'hFFFF;
        default: len = $urandom_range(3000, 1);
      endcase
      el = $urandom;
      push_item(FUNC_APPEND, len, el);
    end else begin
      case ($urandom_range(9))
        0: el = 32'd0;
        1: el = $urandom;
        default: el = $urandom_range(50000, 1);
      endcase
      len = $urandom;
      push_item(FUNC_TICK, len, el);
    end
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int c = 0; c < CHUNKS; c++) begin
      settle();
      reconfigure_random();
      repeat (CHUNK_ITEMS) push_random_item();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_idle_and_zero_length();
    test_full_queue();
    test_byte_limit();
    test_long_ticks();
    test_random_traffic(15, 86);
    test_random_traffic(86, 15);
    test_random_traffic(0, 0);
    settle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: token_bucket_packet_pacer_core.f
+incdir+rtl
rtl/tbpp_pkg.sv
rtl/tbpp_len_mem.sv
rtl/tbpp_refill.sv
rtl/token_bucket_packet_pacer_core.sv
tb/sv/tb.sv
